// ===== sv/vcsp_pkg.sv =====
// shared types, constants and helpers for the voxel chunk stream parser
package vcsp_pkg;

  localparam int OFF_BITS  = 40;
  localparam int MCNT_BITS = 16;
  localparam logic [OFF_BITS-1:0]  OFF_MAX  = {OFF_BITS{1'b1}};
  localparam logic [MCNT_BITS-1:0] MCNT_MAX = {MCNT_BITS{1'b1}};
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [31:0] ID_VOX  = 32'h20584F56;
  localparam logic [31:0] ID_MAIN = 32'h4E49414D;
  localparam logic [31:0] ID_PACK = 32'h4B434150;
  localparam logic [31:0] ID_SIZE = 32'h455A4953;
  localparam logic [31:0] ID_XYZI = 32'h495A5958;
  localparam logic [31:0] ID_RGBA = 32'h41424752;
  localparam logic [7:0]  LAST_SLOT = 8'd255;

  typedef enum logic [2:0] {
    KIND_VERSION = 3'd0,
    KIND_SIZE    = 3'd1,
    KIND_VOXEL   = 3'd2,
    KIND_PAL     = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_MAGIC    = 3'd0,
    ERR_NO_MAIN  = 3'd1,
    ERR_TRUNC    = 3'd2,
    ERR_NEG_SIZE = 3'd3,
    ERR_VOX_CNT  = 3'd4,
    ERR_MDL_CNT  = 3'd5,
    ERR_NO_SIZE  = 3'd6,
    ERR_OVERRUN  = 3'd7
  } err_t;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_VERSION, PH_MAIN_ID, PH_MAIN_CONTENT, PH_MAIN_CHILD,
    PH_FIRST_ID, PH_CHUNK_ID, PH_HDR_CONTENT, PH_HDR_CHILD, PH_PACK_COUNT,
    PH_SIZE_X, PH_SIZE_Y, PH_SIZE_Z, PH_XYZI_COUNT, PH_VOXELS, PH_PALETTE,
    PH_SKIP, PH_DONE
  } phase_t;

  typedef struct packed {
    logic        last;
    logic [2:0]  err;
    logic        rgba;
    logic [7:0]  ent;
    logic [7:0]  w;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [15:0] model;
    logic [2:0]  kind;
  } res_t;

  // one pushed entry holds all results of one byte
  typedef struct packed {
    logic valid;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic res_t make_res(input logic [2:0] kind, input logic [15:0] mi,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic [7:0] w,
                                    input logic [7:0] ent, input logic rs,
                                    input logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.model = mi;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    r.w     = w;
    r.ent   = ent;
    r.rgba  = rs;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/vcsp_front.sv =====
// front: accepts file bytes, assembles words and runs the chunk walk
module vcsp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output vcsp_pkg::push_t push
);
  import vcsp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [OFF_BITS-1:0]   pos_r, pos_nxt;
  logic [OFF_BITS-1:0]   main_end_r, main_end_nxt;
  logic [OFF_BITS-1:0]   chunk_end_r, chunk_end_nxt;
  logic [23:0]           shift_r, shift_nxt;
  logic [1:0]            bif_r, bif_nxt;
  logic [31:0]           cid_r, cid_nxt;
  logic [30:0]           vleft_r, vleft_nxt;
  logic [7:0]            slot_r, slot_nxt;
  logic [63:0]           pend_r, pend_nxt;
  logic [MCNT_BITS-1:0]  mcnt_r, mcnt_nxt;
  logic                  rgba_r, rgba_nxt;

  logic [OFF_BITS-1:0]   pos_inc, bpos;
  logic [OFF_BITS:0]     sum;
  logic [OFF_BITS-1:0]   sat_end;
  logic [31:0]           w;
  logic [15:0]           cur_model;
  logic [30:0]           vdec;
  logic                  do_close, do_bound;
  logic [1:0]            n;
  res_t                  res [2];

  assign pos_inc   = (pos_r < OFF_MAX) ? pos_r + 1'b1 : pos_r;
  assign w         = {in_byte, shift_r};
  assign cur_model = (mcnt_r != '0) ? 16'(mcnt_r - 1'b1) : 16'd0;
  assign sum       = {1'b0, pos_inc} + (OFF_BITS+1)'(pend_r[31:0])
                     + (OFF_BITS+1)'(w);
  assign sat_end   = sum[OFF_BITS] ? OFF_MAX : sum[OFF_BITS-1:0];
  assign vdec      = (vleft_r != '0) ? vleft_r - 1'b1 : vleft_r;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    main_end_nxt  = main_end_r;
    chunk_end_nxt = chunk_end_r;
    shift_nxt     = shift_r;
    bif_nxt       = bif_r;
    cid_nxt       = cid_r;
    vleft_nxt     = vleft_r;
    slot_nxt      = slot_r;
    pend_nxt      = pend_r;
    mcnt_nxt      = mcnt_r;
    rgba_nxt      = rgba_r;
    do_close      = 1'b0;
    do_bound      = 1'b0;
    bpos          = pos_inc;
    n             = 2'd0;
    res[0]        = '0;
    res[1]        = '0;
    if (in_fire && phase_r != PH_DONE) begin
      pos_nxt = pos_inc;
      if (phase_r == PH_SKIP) begin
        if (pos_inc >= chunk_end_r) do_bound = 1'b1;
      end else if (bif_r != 2'd3) begin
        unique case (bif_r)
          2'd0:    shift_nxt = {16'd0, in_byte};
          2'd1:    shift_nxt = {8'd0, in_byte, shift_r[7:0]};
          default: shift_nxt = {in_byte, shift_r[15:0]};
        endcase
        bif_nxt = bif_r + 2'd1;
      end else begin
        shift_nxt = '0;
        bif_nxt   = 2'd0;
        unique case (phase_r)
          PH_MAGIC: begin
            if (w != ID_VOX) begin
              res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0,
                                   1'b0, ERR_MAGIC);
              n = n + 2'd1;
              phase_nxt = PH_DONE;
            end else phase_nxt = PH_VERSION;
          end
          PH_VERSION: begin
            res[n[0]] = make_res(KIND_VERSION, 16'd0, w, 32'd0, 32'd0, 8'd0, 8'd0,
                                 1'b0, 3'd0);
            n = n + 2'd1;
            phase_nxt = PH_MAIN_ID;
          end
          PH_MAIN_ID: begin
            if (w != ID_MAIN) begin
              res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0,
                                   1'b0, ERR_NO_MAIN);
              n = n + 2'd1;
              phase_nxt = PH_DONE;
            end else phase_nxt = PH_MAIN_CONTENT;
          end
          PH_MAIN_CONTENT: begin
            pend_nxt  = {32'd0, w};
            phase_nxt = PH_MAIN_CHILD;
          end
          PH_HDR_CONTENT: begin
            pend_nxt  = {32'd0, w};
            phase_nxt = PH_HDR_CHILD;
          end
          PH_MAIN_CHILD, PH_HDR_CHILD: begin
            if (pend_r[31] || w[31]) begin
              res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0,
                                   1'b0, ERR_NEG_SIZE);
              n = n + 2'd1;
              phase_nxt = PH_DONE;
            end else if (phase_r == PH_MAIN_CHILD) begin
              main_end_nxt = sat_end;
              phase_nxt    = PH_FIRST_ID;
            end else begin
              chunk_end_nxt = sat_end;
              priority if (cid_r == ID_PACK) begin
                phase_nxt = PH_PACK_COUNT;
              end else if (cid_r == ID_SIZE) begin
                if (mcnt_r < MCNT_MAX) mcnt_nxt = mcnt_r + 1'b1;
                phase_nxt = PH_SIZE_X;
              end else if (cid_r == ID_XYZI) begin
                if (mcnt_r == '0) begin
                  res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0,
                                       8'd0, 1'b0, ERR_NO_SIZE);
                  n = n + 2'd1;
                  phase_nxt = PH_DONE;
                end else phase_nxt = PH_XYZI_COUNT;
              end else if (cid_r == ID_RGBA) begin
                slot_nxt  = 8'd0;
                phase_nxt = PH_PALETTE;
              end else begin
                do_close = 1'b1;
              end
            end
          end
          PH_FIRST_ID: begin
            // empty main ends on the fourth id byte unless it is a pack chunk
            if (w == ID_PACK) begin
              cid_nxt   = ID_PACK;
              phase_nxt = PH_HDR_CONTENT;
            end else if (pos_inc - OFF_BITS'(4) >= main_end_r) begin
              bpos     = pos_inc - OFF_BITS'(4);
              do_bound = 1'b1;
            end else begin
              cid_nxt   = w;
              phase_nxt = PH_HDR_CONTENT;
            end
          end
          PH_CHUNK_ID: begin
            cid_nxt   = (w == ID_PACK) ? 32'd0 : w;
            phase_nxt = PH_HDR_CONTENT;
          end
          PH_PACK_COUNT, PH_XYZI_COUNT: begin
            if (w[31] || w == 32'd0) begin
              res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0,
                                   1'b0, (phase_r == PH_PACK_COUNT) ? ERR_MDL_CNT
                                                                    : ERR_VOX_CNT);
              n = n + 2'd1;
              phase_nxt = PH_DONE;
            end else if (phase_r == PH_PACK_COUNT) begin
              do_close = 1'b1;
            end else begin
              vleft_nxt = w[30:0];
              phase_nxt = PH_VOXELS;
            end
          end
          PH_SIZE_X: begin
            pend_nxt  = {32'd0, w};
            phase_nxt = PH_SIZE_Y;
          end
          PH_SIZE_Y: begin
            pend_nxt  = {w, pend_r[31:0]};
            phase_nxt = PH_SIZE_Z;
          end
          PH_SIZE_Z: begin
            res[n[0]] = make_res(KIND_SIZE, cur_model, pend_r[31:0], pend_r[63:32], w,
                                 8'd0, 8'd0, 1'b0, 3'd0);
            n = n + 2'd1;
            do_close = 1'b1;
          end
          PH_VOXELS: begin
            res[n[0]] = make_res(KIND_VOXEL, cur_model, {24'd0, w[7:0]},
                                 {24'd0, w[15:8]}, {24'd0, w[23:16]}, w[31:24], 8'd0,
                                 1'b0, 3'd0);
            n = n + 2'd1;
            vleft_nxt = vdec;
            if (vdec == '0) do_close = 1'b1;
          end
          PH_PALETTE: begin
            if (slot_r < LAST_SLOT) begin
              res[n[0]] = make_res(KIND_PAL, 16'd0, {24'd0, w[7:0]}, {24'd0, w[15:8]},
                                   {24'd0, w[23:16]}, w[31:24], slot_r + 8'd1, 1'b0,
                                   3'd0);
              n = n + 2'd1;
              slot_nxt = slot_r + 8'd1;
            end else begin
              rgba_nxt = 1'b1;
              do_close = 1'b1;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase
      end

      // an unknown chunk closes in the same beat that sets its end
      if (do_close) begin
        priority if (pos_inc > chunk_end_nxt) begin
          res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 1'b0,
                               ERR_OVERRUN);
          n = n + 2'd1;
          phase_nxt = PH_DONE;
        end else if (pos_inc < chunk_end_nxt) begin
          phase_nxt = PH_SKIP;
        end else begin
          do_bound = 1'b1;
        end
      end
      if (do_bound) begin
        if (bpos >= main_end_r) begin
          res[n[0]] = make_res(KIND_END, 16'(mcnt_r), 32'd0, 32'd0, 32'd0, 8'd0, 8'd0,
                               rgba_nxt, 3'd0);
          n = n + 2'd1;
          phase_nxt = PH_DONE;
        end else phase_nxt = PH_CHUNK_ID;
      end
      if (in_last && phase_nxt != PH_DONE) begin
        res[n[0]] = make_res(KIND_ERROR, 16'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 1'b0,
                             ERR_TRUNC);
        n = n + 2'd1;
        phase_nxt = PH_DONE;
      end
      if (n == 2'd1) res[0].last = 1'b1;
      if (n == 2'd2) res[1].last = 1'b1;
    end
    push.valid = (n != 2'd0);
    push.two   = (n == 2'd2);
    push.r0    = res[0];
    push.r1    = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      pos_r       <= '0;
      main_end_r  <= '0;
      chunk_end_r <= '0;
      shift_r     <= '0;
      bif_r       <= '0;
      cid_r       <= '0;
      vleft_r     <= '0;
      slot_r      <= '0;
      pend_r      <= '0;
      mcnt_r      <= '0;
      rgba_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      main_end_r  <= main_end_nxt;
      chunk_end_r <= chunk_end_nxt;
      shift_r     <= shift_nxt;
      bif_r       <= bif_nxt;
      cid_r       <= cid_nxt;
      vleft_r     <= vleft_nxt;
      slot_r      <= slot_nxt;
      pend_r      <= pend_nxt;
      mcnt_r      <= mcnt_nxt;
      rgba_r      <= rgba_nxt;
    end
  end

endmodule

// ===== sv/vcsp_back.sv =====
// back: result queue and one-result-per-beat output while out_ready is high
module vcsp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  vcsp_pkg::push_t push,
  output logic            q_ready,
  output vcsp_pkg::res_t  out_res,
  output logic            out_valid,
  input  logic            out_ready
);
  import vcsp_pkg::*;

  push_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]    cnt_r, cnt_nxt;
  logic             sub_r, sub_nxt;
  logic             pop, fire;

  assign q_ready   = (cnt_r < (Q_AW+1)'(Q_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_res   = sub_r ? mem[rp_r].r1 : mem[rp_r].r0;
  assign fire      = out_valid && out_ready;
  // an entry with a pair of results stays until its second result is taken
  assign pop       = fire && (sub_r || !mem[rp_r].two);

  always_comb begin
    wp_nxt  = push.valid ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    sub_nxt = fire ? !pop : sub_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(push.valid) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem[wp_r] <= push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count past depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (cnt_r < (Q_AW+1)'(Q_DEPTH)) || pop) else $error("push into full queue");
  a_sub_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> out_valid && mem[rp_r].two) else $error("second result without pair");
  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> out_res.last) else $error("entry retired before its last result");
`endif

endmodule

// ===== sv/voxel_chunk_stream_parser_top.sv =====
// top level of the voxel chunk stream parser
// a result is written into the result queue when its byte is taken and leaves from the queue head
// throughput: one byte per cycle while the queue has room; a byte with two results holds the output for both results
// input stalls only when the four-entry result queue is full
// reset (rst_n low, synchronous) returns the parse to the magic check and empties the queue
module voxel_chunk_stream_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // byte_in
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,  // model_index, val_x, val_y, val_z, val_w,
                                    // entry_index, rgba_seen, error_code, zero fill
  output logic [2:0]    out_tuser,  // kind
  output logic          out_tlast
);
  import vcsp_pkg::*;

  push_t push;
  res_t  res;
  logic  q_ready;

  assign in_tready = q_ready;

  vcsp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && q_ready),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push)
  );

  vcsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_ready   (q_ready),
    .out_res   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {4'd0, res.err, res.rgba, res.ent, res.w, res.z, res.y, res.x,
                      res.model};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
